/* sv/irim_pkg.sv */
package irim_pkg;

   // fixed field widths
   localparam int DIM_W  = 9;
   localparam int SIZE_W = 10;
   localparam int TRIG_W = 16;
   localparam int CHAN_W = 8;
   localparam int PIX_W  = 3 * CHAN_W;
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [DIM_W-1:0]         DIM_RESET  = 9'd256;
   localparam logic signed [TRIG_W-1:0] COS_RESET  = 16'sd16384;
   localparam logic signed [TRIG_W-1:0] SIN_RESET  = 16'sd0;
   localparam logic [SIZE_W-1:0]        SIZE_RESET = 10'd256;
   localparam int                       SIZE_SAT   = 1023;

   typedef enum logic [1:0] {
      REG_SRC_WIDTH,
      REG_SRC_HEIGHT,
      REG_COS_ANGLE,
      REG_SIN_ANGLE
   } csr_reg_type;

   typedef enum logic [2:0] {
      GEO_IDLE,
      GEO_CORNER,
      GEO_DRAIN,
      GEO_SIZE,
      GEO_OFFSET
   } geo_state_type;

   typedef struct packed {
      logic en;
      logic we;
   } mem_cmd_type;

   typedef struct packed {
      logic valid;
      logic rd;
      logic in_src;
   } pipe_ctl_type;

   // width of the rotated corner sums
   function automatic int calc_geo_w(input int trig_frac);
      int pr_w;
      int cen_w;
      pr_w  = DIM_W + 2 + TRIG_W;
      cen_w = DIM_W + trig_frac;
      return ((pr_w > cen_w) ? pr_w : cen_w) + 2;
   endfunction

   // width of the centering offsets
   function automatic int calc_ofs_w(input int trig_frac, input int coord_frac);
      return calc_geo_w(trig_frac) + 3 + coord_frac - trig_frac;
   endfunction

endpackage

/* sv/irim_pixel_mem.sv */
module irim_pixel_mem #(
   parameter int DEPTH = 65536
) (
   input  logic                              clock,
   input  irim_pkg::mem_cmd_type             cmd,
   input  logic [$clog2(DEPTH)-1:0]          addr,
   input  logic [irim_pkg::PIX_W-1:0]        wdata,
   output logic [irim_pkg::PIX_W-1:0]        rdata
);

   logic [irim_pkg::PIX_W-1:0] mem_ff [DEPTH];
   logic [irim_pkg::PIX_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.en && cmd.we) begin
         mem_ff[addr] <= wdata;
      end
      if (cmd.en && !cmd.we) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* sv/irim_geom.sv */
module irim_geom #(
   parameter int TRIG_FRAC_BITS  = 14,
   parameter int COORD_FRAC_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                restart,
   input  logic [irim_pkg::DIM_W-1:0]          src_width,
   input  logic [irim_pkg::DIM_W-1:0]          src_height,
   input  logic signed [irim_pkg::TRIG_W-1:0]  cos_angle,
   input  logic signed [irim_pkg::TRIG_W-1:0]  sin_angle,
   output logic                                busy,
   output logic signed [irim_pkg::calc_ofs_w(TRIG_FRAC_BITS, COORD_FRAC_BITS)-1:0] offset_x,
   output logic signed [irim_pkg::calc_ofs_w(TRIG_FRAC_BITS, COORD_FRAC_BITS)-1:0] offset_y,
   output logic [irim_pkg::SIZE_W-1:0]         rot_width,
   output logic [irim_pkg::SIZE_W-1:0]         rot_height
);

   localparam int PX_W  = irim_pkg::DIM_W + 2;
   localparam int PR_W  = PX_W + irim_pkg::TRIG_W;
   localparam int G_W   = irim_pkg::calc_geo_w(TRIG_FRAC_BITS);
   localparam int N_W   = G_W + 2;
   localparam int D_W   = N_W + 1;
   localparam int OFS_W = irim_pkg::calc_ofs_w(TRIG_FRAC_BITS, COORD_FRAC_BITS);
   localparam int SH    = TRIG_FRAC_BITS + 1 - COORD_FRAC_BITS;
   localparam int SH_R  = (SH > 0) ? SH : 0;
   localparam int SH_L  = (SH > 0) ? 0 : -SH;
   localparam int HALF_SH = (SH_R > 0) ? SH_R - 1 : 0;

   localparam logic signed [PX_W-1:0] PX_ONE   = PX_W'(1);
   localparam logic signed [N_W-1:0]  ONE_N    = N_W'(1) <<< TRIG_FRAC_BITS;
   localparam logic signed [N_W-1:0]  SAT_HI   = N_W'(irim_pkg::SIZE_SAT);
   localparam logic signed [N_W-1:0]  SAT_LO   = N_W'(1);
   localparam logic signed [D_W-1:0]  HALF_D   = (SH_R > 0) ? (D_W'(1) <<< HALF_SH) : D_W'(0);

   irim_pkg::geo_state_type state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic issue, acc_size, acc_ofs;

   logic signed [PX_W-1:0] px, py;
   logic [irim_pkg::DIM_W-2:0] cx, cy;
   logic signed [PR_W-1:0] pxc_ff, pys_ff, pxs_ff, pyc_ff;
   logic prod_vld_ff, prod_first_ff;
   logic signed [G_W-1:0] xr, yr, cen_x, cen_y;
   logic signed [G_W-1:0] l_ff, r_ff, t_ff, b_ff;
   logic signed [N_W-1:0] nw_ff, nh_ff, cw, ch;
   logic signed [D_W-1:0] dvx, dvy;

   // half away from zero, then into offset format
   function automatic logic signed [OFS_W-1:0] to_coord(input logic signed [D_W-1:0] v);
      logic signed [D_W-1:0] mag;
      logic signed [D_W-1:0] q;
      mag = (v < 0) ? -v : v;
      q   = (mag + HALF_D) >> SH_R;
      q   = (v < 0) ? -q : q;
      return OFS_W'(q) <<< SH_L;
   endfunction

   function automatic logic [irim_pkg::SIZE_W-1:0] sat_size(input logic signed [N_W-1:0] v);
      logic [irim_pkg::SIZE_W-1:0] r;
      if (v > SAT_HI) begin
         r = irim_pkg::SIZE_W'(irim_pkg::SIZE_SAT);
      end else if (v < SAT_LO) begin
         r = irim_pkg::SIZE_W'(1);
      end else begin
         r = v[irim_pkg::SIZE_W-1:0];
      end
      return r;
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         irim_pkg::GEO_IDLE:   state_in = irim_pkg::GEO_IDLE;
         irim_pkg::GEO_CORNER: begin
            if (idx_ff == 2'd3) begin
               state_in = irim_pkg::GEO_DRAIN;
            end
         end
         irim_pkg::GEO_DRAIN:  state_in = irim_pkg::GEO_SIZE;
         irim_pkg::GEO_SIZE:   state_in = irim_pkg::GEO_OFFSET;
         irim_pkg::GEO_OFFSET: state_in = irim_pkg::GEO_IDLE;
         default:              state_in = irim_pkg::GEO_IDLE;
      endcase
      if (restart) begin
         state_in = irim_pkg::GEO_CORNER;
      end
   end

   // outputs of the sequencer
   always_comb begin
      busy     = 1'b1;
      issue    = 1'b0;
      acc_size = 1'b0;
      acc_ofs  = 1'b0;
      unique case (state_ff)
         irim_pkg::GEO_IDLE:   busy     = 1'b0;
         irim_pkg::GEO_CORNER: issue    = 1'b1;
         irim_pkg::GEO_DRAIN:  busy     = 1'b1;
         irim_pkg::GEO_SIZE:   acc_size = 1'b1;
         irim_pkg::GEO_OFFSET: acc_ofs  = 1'b1;
         default:              busy     = 1'b1;
      endcase
   end

   assign idx_in = restart ? 2'd0 : (issue ? idx_ff + 2'd1 : idx_ff);

   // corner relative to the integer center
   assign cx = src_width[irim_pkg::DIM_W-1:1];
   assign cy = src_height[irim_pkg::DIM_W-1:1];
   assign px = (idx_ff[0] ? ($signed({2'b00, src_width}) - PX_ONE) : PX_W'(0))
               - $signed(PX_W'(cx));
   assign py = (idx_ff[1] ? ($signed({2'b00, src_height}) - PX_ONE) : PX_W'(0))
               - $signed(PX_W'(cy));

   assign cen_x = $signed(G_W'(cx)) <<< TRIG_FRAC_BITS;
   assign cen_y = $signed(G_W'(cy)) <<< TRIG_FRAC_BITS;
   assign xr    = G_W'(pxc_ff) - G_W'(pys_ff) + cen_x;
   assign yr    = G_W'(pxs_ff) + G_W'(pyc_ff) + cen_y;

   assign cw  = (nw_ff + ONE_N - N_W'(1)) >>> TRIG_FRAC_BITS;
   assign ch  = (nh_ff + ONE_N - N_W'(1)) >>> TRIG_FRAC_BITS;
   assign dvx = D_W'(nw_ff) - ($signed(D_W'(src_width)) <<< TRIG_FRAC_BITS);
   assign dvy = D_W'(nh_ff) - ($signed(D_W'(src_height)) <<< TRIG_FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= irim_pkg::GEO_CORNER;
         idx_ff      <= 2'd0;
         prod_vld_ff <= 1'b0;
         offset_x    <= '0;
         offset_y    <= '0;
         rot_width   <= irim_pkg::SIZE_RESET;
         rot_height  <= irim_pkg::SIZE_RESET;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         prod_vld_ff <= issue && !restart;
         if (acc_ofs && !restart) begin
            offset_x   <= to_coord(dvx);
            offset_y   <= to_coord(dvy);
            rot_width  <= sat_size(cw);
            rot_height <= sat_size(ch);
         end
      end
   end

   // corner products and bounding box
   always_ff @(posedge clock) begin
      if (issue) begin
         pxc_ff        <= PR_W'(px) * PR_W'(cos_angle);
         pys_ff        <= PR_W'(py) * PR_W'(sin_angle);
         pxs_ff        <= PR_W'(px) * PR_W'(sin_angle);
         pyc_ff        <= PR_W'(py) * PR_W'(cos_angle);
         prod_first_ff <= (idx_ff == 2'd0);
      end
      if (prod_vld_ff) begin
         if (prod_first_ff || xr < l_ff) l_ff <= xr;
         if (prod_first_ff || xr > r_ff) r_ff <= xr;
         if (prod_first_ff || yr < t_ff) t_ff <= yr;
         if (prod_first_ff || yr > b_ff) b_ff <= yr;
      end
      if (acc_size) begin
         nw_ff <= N_W'(r_ff) - N_W'(l_ff) + ONE_N;
         nh_ff <= N_W'(b_ff) - N_W'(t_ff) + ONE_N;
      end
   end

endmodule

/* sv/irim_map.sv */
module irim_map #(
   parameter int MAX_WIDTH       = 256,
   parameter int MAX_HEIGHT      = 256,
   parameter int TRIG_FRAC_BITS  = 14,
   parameter int COORD_FRAC_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                req_mode,
   input  logic [irim_pkg::DIM_W-1:0]          req_col,
   input  logic [irim_pkg::DIM_W-1:0]          req_row,
   input  logic [irim_pkg::PIX_W-1:0]          req_pixel,
   input  logic [irim_pkg::DIM_W-1:0]          src_width,
   input  logic [irim_pkg::DIM_W-1:0]          src_height,
   input  logic signed [irim_pkg::TRIG_W-1:0]  cos_angle,
   input  logic signed [irim_pkg::TRIG_W-1:0]  sin_angle,
   input  logic signed [irim_pkg::calc_ofs_w(TRIG_FRAC_BITS, COORD_FRAC_BITS)-1:0] offset_x,
   input  logic signed [irim_pkg::calc_ofs_w(TRIG_FRAC_BITS, COORD_FRAC_BITS)-1:0] offset_y,
   output irim_pkg::mem_cmd_type               mem_cmd,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] mem_addr,
   output logic [irim_pkg::PIX_W-1:0]          mem_wdata,
   output irim_pkg::pipe_ctl_type              ctl
);

   localparam int OFS_W  = irim_pkg::calc_ofs_w(TRIG_FRAC_BITS, COORD_FRAC_BITS);
   localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int COL_W  = irim_pkg::DIM_W + 1 + COORD_FRAC_BITS;
   localparam int DW     = ((OFS_W > COL_W) ? OFS_W : COL_W) + 2;
   localparam int PW     = DW + irim_pkg::TRIG_W;
   localparam int CEN_W  = irim_pkg::DIM_W + COORD_FRAC_BITS + TRIG_FRAC_BITS;
   localparam int SW     = ((PW > CEN_W) ? PW : CEN_W) + 2;
   localparam int R      = COORD_FRAC_BITS + TRIG_FRAC_BITS;
   localparam int QW     = SW - R + 1;
   localparam int CMPW   = ((QW > 14) ? QW : 14) + 1;

   localparam logic signed [SW-1:0] HALF_S = SW'(1) <<< (R - 1);

   logic [irim_pkg::DIM_W-2:0] cx, cy;

   // stage 1: offsets removed
   logic s1_vld_ff, s1_rd_ff;
   logic signed [DW-1:0] dx_ff, dy_ff;
   logic [irim_pkg::DIM_W-1:0] s1_col_ff, s1_row_ff;
   logic [irim_pkg::PIX_W-1:0] s1_pix_ff;
   logic signed [DW-1:0] dx_in, dy_in;

   // stage 2: products
   logic s2_vld_ff, s2_rd_ff;
   logic signed [PW-1:0] p_dxc_ff, p_dys_ff, p_dxs_ff, p_dyc_ff;
   logic [irim_pkg::DIM_W-1:0] s2_col_ff, s2_row_ff;
   logic [irim_pkg::PIX_W-1:0] s2_pix_ff;

   // stage 3: rotated source coordinate
   logic s3_vld_ff, s3_rd_ff;
   logic signed [SW-1:0] sxq_ff, syq_ff, sxq_in, syq_in;
   logic [irim_pkg::DIM_W-1:0] s3_col_ff, s3_row_ff;
   logic [irim_pkg::PIX_W-1:0] s3_pix_ff;

   // stage 4: rounded, memory access
   logic s4_vld_ff, s4_rd_ff;
   logic signed [QW-1:0] sx_ff, sy_ff;
   logic [irim_pkg::DIM_W-1:0] s4_col_ff, s4_row_ff;
   logic [irim_pkg::PIX_W-1:0] s4_pix_ff;

   logic signed [CMPW-1:0] sxc, syc, wlim, hlim;
   logic in_src, wr_ok;
   logic [ADDR_W-1:0] xi, yi;

   function automatic logic signed [QW-1:0] round_q(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] mag;
      logic signed [SW-1:0] q;
      mag = (v < 0) ? -v : v;
      q   = (mag + HALF_S) >> R;
      q   = (v < 0) ? -q : q;
      return QW'(q);
   endfunction

   assign cx = src_width[irim_pkg::DIM_W-1:1];
   assign cy = src_height[irim_pkg::DIM_W-1:1];

   assign dx_in = ($signed(DW'(req_col)) <<< COORD_FRAC_BITS) - DW'(offset_x)
                  - ($signed(DW'(cx)) <<< COORD_FRAC_BITS);
   assign dy_in = ($signed(DW'(req_row)) <<< COORD_FRAC_BITS) - DW'(offset_y)
                  - ($signed(DW'(cy)) <<< COORD_FRAC_BITS);

   assign sxq_in = SW'(p_dxc_ff) + SW'(p_dys_ff) + ($signed(SW'(cx)) <<< R);
   assign syq_in = SW'(p_dyc_ff) - SW'(p_dxs_ff) + ($signed(SW'(cy)) <<< R);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_rd_ff  <= req_mode;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      s1_col_ff <= req_col;
      s1_row_ff <= req_row;
      s1_pix_ff <= req_pixel;

      s2_rd_ff  <= s1_rd_ff;
      p_dxc_ff  <= PW'(dx_ff) * PW'(cos_angle);
      p_dys_ff  <= PW'(dy_ff) * PW'(sin_angle);
      p_dxs_ff  <= PW'(dx_ff) * PW'(sin_angle);
      p_dyc_ff  <= PW'(dy_ff) * PW'(cos_angle);
      s2_col_ff <= s1_col_ff;
      s2_row_ff <= s1_row_ff;
      s2_pix_ff <= s1_pix_ff;

      s3_rd_ff  <= s2_rd_ff;
      sxq_ff    <= sxq_in;
      syq_ff    <= syq_in;
      s3_col_ff <= s2_col_ff;
      s3_row_ff <= s2_row_ff;
      s3_pix_ff <= s2_pix_ff;

      s4_rd_ff  <= s3_rd_ff;
      sx_ff     <= round_q(sxq_ff);
      sy_ff     <= round_q(syq_ff);
      s4_col_ff <= s3_col_ff;
      s4_row_ff <= s3_row_ff;
      s4_pix_ff <= s3_pix_ff;
   end

   // bounds of the source image and of the store
   assign sxc  = CMPW'(sx_ff);
   assign syc  = CMPW'(sy_ff);
   assign wlim = $signed(CMPW'(src_width)) - CMPW'(1);
   assign hlim = $signed(CMPW'(src_height)) - CMPW'(1);
   assign in_src = (sxc >= 0) && (sxc <= wlim) && (syc >= 0) && (syc <= hlim)
                   && (sxc < CMPW'(MAX_WIDTH)) && (syc < CMPW'(MAX_HEIGHT));
   assign wr_ok  = (32'(s4_col_ff) < MAX_WIDTH) && (32'(s4_row_ff) < MAX_HEIGHT);

   assign xi = s4_rd_ff ? ADDR_W'(sx_ff) : ADDR_W'(s4_col_ff);
   assign yi = s4_rd_ff ? ADDR_W'(sy_ff) : ADDR_W'(s4_row_ff);

   assign mem_addr   = yi * ADDR_W'(MAX_WIDTH) + xi;
   assign mem_wdata  = s4_pix_ff;
   assign mem_cmd.en = s4_vld_ff && (s4_rd_ff ? in_src : wr_ok);
   assign mem_cmd.we = !s4_rd_ff;

   assign ctl.valid  = s4_vld_ff;
   assign ctl.rd     = s4_rd_ff;
   assign ctl.in_src = in_src;

endmodule

/* sv/image_rotate_inverse_map_core.sv */
// image rotation by inverse mapping, nearest-neighbor sampling
//
// item channel: start with busy low accepts one item. req_mode 0 stores the
// pixel req_red_in/green_in/blue_in at (req_col, req_row); req_mode 1 asks
// for the output pixel at (req_col, req_row), which is mapped back into the
// source image and sampled there
// result channel: each request gives one result, shown for exactly one cycle
// with rsp_strobe high; writes give none. the receiver cannot stall, so the
// block never holds a result back
// pipe: one item of either kind is accepted every cycle while busy is low;
// reads and writes go through the same five-stage pipe and hit the pixel
// memory's single port in order, so no forwarding is needed
// csr port: width, height, cosine, sine. every write reruns the geometry
// sequencer (four corner steps, drain, size, offsets) and busy stays high
// meanwhile. reset loads the default registers and runs the same pass; the
// pixel memory is not cleared
module image_rotate_inverse_map_core #(
   parameter int MAX_WIDTH       = 256,
   parameter int MAX_HEIGHT      = 256,
   parameter int TRIG_FRAC_BITS  = 14,
   parameter int COORD_FRAC_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,

   // item channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_mode,
   input  logic [irim_pkg::DIM_W-1:0]           req_col,
   input  logic [irim_pkg::DIM_W-1:0]           req_row,
   input  logic [irim_pkg::CHAN_W-1:0]          req_red_in,
   input  logic [irim_pkg::CHAN_W-1:0]          req_green_in,
   input  logic [irim_pkg::CHAN_W-1:0]          req_blue_in,

   // result channel
   output logic                                 rsp_strobe,
   output logic [irim_pkg::CHAN_W-1:0]          rsp_red_out,
   output logic [irim_pkg::CHAN_W-1:0]          rsp_green_out,
   output logic [irim_pkg::CHAN_W-1:0]          rsp_blue_out,
   output logic                                 rsp_inside_res,
   output logic [irim_pkg::SIZE_W-1:0]          rsp_out_width,
   output logic [irim_pkg::SIZE_W-1:0]          rsp_out_height,

   // csr port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [irim_pkg::CSR_AW-1:0]          paddr,
   input  logic [irim_pkg::CSR_DW-1:0]          pwdata,
   output logic [irim_pkg::CSR_DW-1:0]          prdata,
   output logic                                 pready
);

   localparam int OFS_W  = irim_pkg::calc_ofs_w(TRIG_FRAC_BITS, COORD_FRAC_BITS);
   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   // configuration registers
   logic [irim_pkg::DIM_W-1:0]         src_width_ff, src_height_ff;
   logic signed [irim_pkg::TRIG_W-1:0] cos_angle_ff, sin_angle_ff;
   logic                               csr_wr;
   irim_pkg::csr_reg_type              csr_sel;

   // geometry results
   logic                               geo_busy;
   logic signed [OFS_W-1:0]            offset_x, offset_y;
   logic [irim_pkg::SIZE_W-1:0]        rot_width, rot_height;

   // pipe and memory
   logic                               accept;
   irim_pkg::mem_cmd_type              mem_cmd;
   logic [ADDR_W-1:0]                  mem_addr;
   logic [irim_pkg::PIX_W-1:0]         mem_wdata, mem_rdata;
   irim_pkg::pipe_ctl_type             ctl, out_ctl_ff, out_ctl_in;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_sel = irim_pkg::csr_reg_type'(paddr[3:2]);

   // register writes, word index from the byte address
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= irim_pkg::DIM_RESET;
         src_height_ff <= irim_pkg::DIM_RESET;
         cos_angle_ff  <= irim_pkg::COS_RESET;
         sin_angle_ff  <= irim_pkg::SIN_RESET;
      end else if (csr_wr) begin
         unique case (csr_sel)
            irim_pkg::REG_SRC_WIDTH:  src_width_ff  <= pwdata[irim_pkg::DIM_W-1:0];
            irim_pkg::REG_SRC_HEIGHT: src_height_ff <= pwdata[irim_pkg::DIM_W-1:0];
            irim_pkg::REG_COS_ANGLE:  cos_angle_ff  <= pwdata[irim_pkg::TRIG_W-1:0];
            irim_pkg::REG_SIN_ANGLE:  sin_angle_ff  <= pwdata[irim_pkg::TRIG_W-1:0];
            default:                  src_width_ff  <= src_width_ff;
         endcase
      end
   end

   // readback, signed registers sign extended
   always_comb begin
      unique case (csr_sel)
         irim_pkg::REG_SRC_WIDTH:  prdata = irim_pkg::CSR_DW'(src_width_ff);
         irim_pkg::REG_SRC_HEIGHT: prdata = irim_pkg::CSR_DW'(src_height_ff);
         irim_pkg::REG_COS_ANGLE:  prdata = irim_pkg::CSR_DW'(cos_angle_ff);
         irim_pkg::REG_SIN_ANGLE:  prdata = irim_pkg::CSR_DW'(sin_angle_ff);
         default:                  prdata = '0;
      endcase
   end

   // bounding box, output size and centering offsets
   irim_geom #(
      .TRIG_FRAC_BITS  (TRIG_FRAC_BITS),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_geom (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_wr),
      .src_width  (src_width_ff),
      .src_height (src_height_ff),
      .cos_angle  (cos_angle_ff),
      .sin_angle  (sin_angle_ff),
      .busy       (geo_busy),
      .offset_x   (offset_x),
      .offset_y   (offset_y),
      .rot_width  (rot_width),
      .rot_height (rot_height)
   );

   // only the geometry pass holds items off
   assign busy   = geo_busy;
   assign accept = start && !busy;

   // inverse mapping pipe, ends in the memory access
   irim_map #(
      .MAX_WIDTH       (MAX_WIDTH),
      .MAX_HEIGHT      (MAX_HEIGHT),
      .TRIG_FRAC_BITS  (TRIG_FRAC_BITS),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_map (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_mode   (req_mode),
      .req_col    (req_col),
      .req_row    (req_row),
      .req_pixel  ({req_red_in, req_green_in, req_blue_in}),
      .src_width  (src_width_ff),
      .src_height (src_height_ff),
      .cos_angle  (cos_angle_ff),
      .sin_angle  (sin_angle_ff),
      .offset_x   (offset_x),
      .offset_y   (offset_y),
      .mem_cmd    (mem_cmd),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .ctl        (ctl)
   );

   // source pixel store, one port, registered read
   irim_pixel_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock (clock),
      .cmd   (mem_cmd),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // output stage lines up with the memory read data
   assign out_ctl_in = ctl;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ctl_ff <= '0;
      end else begin
         out_ctl_ff <= out_ctl_in;
      end
   end

   assign rsp_strobe     = out_ctl_ff.valid && out_ctl_ff.rd;
   assign rsp_inside_res = out_ctl_ff.in_src;
   // black when the point falls outside the source
   assign rsp_red_out    = out_ctl_ff.in_src ? mem_rdata[23:16] : '0;
   assign rsp_green_out  = out_ctl_ff.in_src ? mem_rdata[15:8]  : '0;
   assign rsp_blue_out   = out_ctl_ff.in_src ? mem_rdata[7:0]   : '0;
   assign rsp_out_width  = rot_width;
   assign rsp_out_height = rot_height;

endmodule

/* sv/irim_checker.sv */
module irim_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_mode,
   input logic rsp_strobe,
   input logic psel,
   input logic penable,
   input logic pwrite
);

   // every request comes back after the fixed pipe depth
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode |-> ##5 rsp_strobe)
      else $error("request without result");

   // no result appears without an earlier accepted request
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && req_mode, 5))
      else $error("result without request");

   // a register write starts the geometry pass
   assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite |=> busy)
      else $error("no geometry pass after write");

   // reset starts the geometry pass too
   assert property (@(posedge clock)
      reset |=> busy)
      else $error("no geometry pass after reset");

endmodule

bind image_rotate_inverse_map_core irim_checker u_irim_checker (.*);
